// ===== hdl/swf_pkg.sv =====
// Package for the sliding window image filter: shared types and constants.
// No dependencies; used by the interfaces and every module of the block.
package swf_pkg;

  localparam int TAP_BITS = 16;
  localparam int OUT_BITS = 40;
  localparam int POS_BITS = 10;
  localparam int DIM_BITS = 11;
  localparam int FLT_BITS = 3;
  localparam int IDX_BITS = 2;

  // Largest image row and largest kernel side; larger configured values are clamped.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_FILTER = 5;

  // Configuration register indexes.
  localparam logic [IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_FILTER_HEIGHT = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_FILTER_WIDTH  = 2'd3;

  localparam logic KIND_TAP   = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Control passed from the sequencer to the channel lanes.
  typedef struct packed {
    logic clear;
    logic acc_en;
  } lane_ctrl_t;

endpackage

// ===== hdl/swf_if.sv =====
// Channel interfaces of the filter: input items and output results.
// Depends on swf_pkg for field widths.
interface swf_in_if import swf_pkg::*; #(parameter int SAMPLE_BITS = 18);
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [2:0]                  tap_row;
  logic [2:0]                  tap_col;
  logic signed [TAP_BITS-1:0]  tap_value;
  logic signed [SAMPLE_BITS-1:0] pixel_ch0;
  logic signed [SAMPLE_BITS-1:0] pixel_ch1;
  logic signed [SAMPLE_BITS-1:0] pixel_ch2;
  modport source (output valid, kind, tap_row, tap_col, tap_value,
                  pixel_ch0, pixel_ch1, pixel_ch2, input ready);
  modport sink (input valid, kind, tap_row, tap_col, tap_value,
                pixel_ch0, pixel_ch1, pixel_ch2, output ready);
endinterface

interface swf_out_if import swf_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [OUT_BITS-1:0]  out_ch0;
  logic signed [OUT_BITS-1:0]  out_ch1;
  logic signed [OUT_BITS-1:0]  out_ch2;
  logic [POS_BITS-1:0]         out_row;
  logic [POS_BITS-1:0]         out_col;
  logic                        last;
  modport source (output valid, out_ch0, out_ch1, out_ch2, out_row, out_col, last,
                  input ready);
  modport sink (input valid, out_ch0, out_ch1, out_ch2, out_row, out_col, last,
                output ready);
endinterface

// ===== hdl/swf_lane.sv =====
// One channel lane: a registered multiply of sample by tap, then accumulate.
// Depends on swf_pkg for the lane control struct and widths.
module swf_lane import swf_pkg::*; #(
  parameter int SAMPLE_BITS = 18
) (
  input  logic                          clk,
  input  lane_ctrl_t                    ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [TAP_BITS-1:0]    tap,
  output logic signed [OUT_BITS-1:0]    acc
);

  logic signed [SAMPLE_BITS+TAP_BITS-1:0] prod;

  // Product stage, then accumulation of the registered product.
  always_ff @(posedge clk) begin
    prod <= sample * tap;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + OUT_BITS'(prod);
    end
  end

endmodule

// ===== hdl/sliding_window_image_filter_core.sv =====
// Top level of the sliding window image filter: line buffer, tap store,
// window sequencer, three channel lanes and the output register.
// Depends on swf_pkg, swf_if and swf_lane.
//
//  channel | dir | payload
//  pix     | in  | kind, tap_row, tap_col, tap_value, pixel_ch0..2
//  res     | out | out_ch0..2, out_row, out_col, last
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// A pixel that completes a window passes ST_DR1, ST_RUN, ST_DR2, ST_DR3 and
// ST_OUT; in ST_RUN one line buffer read per tap serves the three lanes, each
// with its own multiplier; other pixels are only written. Reset is synchronous
// and clears position and control; buffers are undefined until written. A
// result waits in the output register; the next item is taken meanwhile, and
// a further result stalls only until the register empties.
module sliding_window_image_filter_core import swf_pkg::*; #(
  parameter int SAMPLE_BITS = 18
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0] cfg_data,
  swf_in_if.sink              pix,
  swf_out_if.source           res
);

  localparam int SLOT_BITS = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
  localparam int TAPN      = MAX_FILTER * MAX_FILTER;
  localparam int TIDX_BITS = (TAPN > 1) ? $clog2(TAPN) : 1;
  localparam int MEM_DEPTH = MAX_FILTER * MAX_WIDTH;
  localparam int MEM_BITS  = $clog2(MEM_DEPTH);
  localparam int WORD_BITS = 3 * SAMPLE_BITS;
  localparam int CNT_BITS  = DIM_BITS + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_DR1  = 3'd2;
  localparam logic [2:0] ST_DR2  = 3'd3;
  localparam logic [2:0] ST_DR3  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // Configuration registers.
  logic [DIM_BITS-1:0] image_width, image_height;
  logic [FLT_BITS-1:0] filter_height, filter_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= DIM_BITS'(1024);
      image_height  <= DIM_BITS'(1024);
      filter_height <= FLT_BITS'(3);
      filter_width  <= FLT_BITS'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_FILTER_HEIGHT: filter_height <= cfg_data[FLT_BITS-1:0];
        REG_FILTER_WIDTH:  filter_width  <= cfg_data[FLT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamped dimensions.
  logic [CNT_BITS-1:0] w, h;
  logic [3:0]          fh, fw;
  always_comb begin
    w  = (image_width == '0) ? CNT_BITS'(1) :
         (image_width > DIM_BITS'(MAX_WIDTH)) ? CNT_BITS'(MAX_WIDTH) : CNT_BITS'(image_width);
    h  = (image_height == '0) ? CNT_BITS'(1) :
         (image_height > DIM_BITS'(MAX_WIDTH)) ? CNT_BITS'(MAX_WIDTH) : CNT_BITS'(image_height);
    fh = (filter_height == '0) ? 4'd1 :
         (filter_height > FLT_BITS'(MAX_FILTER)) ? 4'(MAX_FILTER) : 4'(filter_height);
    fw = (filter_width == '0) ? 4'd1 :
         (filter_width > FLT_BITS'(MAX_FILTER)) ? 4'(MAX_FILTER) : 4'(filter_width);
  end

  // Tap store: small array, written on tap items, read at the sequencer index.
  logic signed [TAP_BITS-1:0] tap_store [TAPN];
  logic signed [TAP_BITS-1:0] tap_q;

  // Line buffer memory: MAX_FILTER rows of MAX_WIDTH pixels.
  logic [WORD_BITS-1:0] line_store [MEM_DEPTH];
  logic [WORD_BITS-1:0] line_q;

  logic [2:0]          state;
  logic [CNT_BITS-1:0] pixel_row, pixel_col;
  logic [CNT_BITS-1:0] cur_row, cur_col;
  logic [SLOT_BITS-1:0] cur_slot, slot_next;
  logic [SLOT_BITS-1:0] rd_slot;
  logic [3:0]          dy, dx;
  logic                rd_valid, acc_valid;
  logic                is_last;
  logic                out_full;

  wire accept = pix.valid && pix.ready;
  assign pix.ready = (state == ST_IDLE);

  // Position of the incoming pixel, after wrapping on changed dimensions.
  logic [CNT_BITS-1:0] r_eff, c_eff;
  always_comb begin
    r_eff = pixel_row;
    c_eff = pixel_col;
    if (pixel_col >= w) begin
      c_eff = '0;
      r_eff = pixel_row + 1'b1;
    end
    if (r_eff >= h) r_eff = '0;
  end

  // Slot of the incoming row, kept modulo MAX_FILTER by a running counter.
  // Rows only ever advance by one or restart at zero.
  always_comb begin
    slot_next = cur_slot;
    if (r_eff != cur_row) begin
      if (r_eff == '0) slot_next = '0;
      else if (cur_slot == SLOT_BITS'(MAX_FILTER - 1)) slot_next = '0;
      else slot_next = cur_slot + 1'b1;
    end
  end

  wire emit = (r_eff + 1'b1 >= CNT_BITS'(fh)) && (c_eff + 1'b1 >= CNT_BITS'(fw));

  // Read addressing for the window walk.
  logic [CNT_BITS-1:0] ocol, orow;
  assign ocol = cur_col + 1'b1 - CNT_BITS'(fw);
  assign orow = cur_row + 1'b1 - CNT_BITS'(fh);
  wire [MEM_BITS-1:0] wr_addr = MEM_BITS'(slot_next) * MEM_BITS'(MAX_WIDTH)
                                + MEM_BITS'(c_eff);
  wire [MEM_BITS-1:0] rd_addr = MEM_BITS'(rd_slot) * MEM_BITS'(MAX_WIDTH)
                                + MEM_BITS'(ocol + CNT_BITS'(dx));
  wire [TIDX_BITS-1:0] tap_rd = TIDX_BITS'(dy) * TIDX_BITS'(MAX_FILTER) + TIDX_BITS'(dx);
  wire [TIDX_BITS-1:0] tap_wr = TIDX_BITS'(pix.tap_row) * TIDX_BITS'(MAX_FILTER)
                                + TIDX_BITS'(pix.tap_col);
  wire walk_last = (dx == fw - 1'b1) && (dy == fh - 1'b1);

  // Memories: clocked write, registered read.
  always_ff @(posedge clk) begin
    if (accept && pix.kind == KIND_PIXEL) begin
      line_store[wr_addr] <= {pix.pixel_ch2, pix.pixel_ch1, pix.pixel_ch0};
    end
    if (accept && pix.kind == KIND_TAP && pix.tap_row < 3'(MAX_FILTER)
        && pix.tap_col < 3'(MAX_FILTER)) begin
      tap_store[tap_wr] <= pix.tap_value;
    end
    line_q <= line_store[rd_addr];
    tap_q  <= tap_store[tap_rd];
  end

  // Sequencer: accept, walk the window one tap per cycle, drain, hand over.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pixel_row <= '0;
      pixel_col <= '0;
      cur_row   <= '0;
      cur_slot  <= '0;
      rd_valid  <= 1'b0;
      acc_valid <= 1'b0;
    end else begin
      rd_valid  <= (state == ST_RUN);
      acc_valid <= rd_valid;
      unique case (state)
        ST_IDLE: begin
          if (accept && pix.kind == KIND_PIXEL) begin
            cur_row  <= r_eff;
            cur_col  <= c_eff;
            cur_slot <= slot_next;
            is_last  <= (r_eff + 1'b1 == h) && (c_eff + 1'b1 == w);
            if (c_eff + 1'b1 >= w) begin
              pixel_col <= '0;
              pixel_row <= (r_eff + 1'b1 >= h) ? '0 : r_eff + 1'b1;
            end else begin
              pixel_col <= c_eff + 1'b1;
              pixel_row <= r_eff;
            end
            dy <= '0;
            dx <= '0;
            rd_slot <= '0;
            if (emit) state <= ST_DR1;
          end
        end
        ST_DR1: begin
          // Slot of the window's first row, fh-1 rows above the current one.
          rd_slot <= (cur_slot >= SLOT_BITS'(fh - 1'b1)) ?
                     cur_slot - SLOT_BITS'(fh - 1'b1) :
                     cur_slot + SLOT_BITS'(MAX_FILTER) - SLOT_BITS'(fh - 1'b1);
          state   <= ST_RUN;
        end
        ST_RUN: begin
          if (walk_last) begin
            state <= ST_DR2;
          end else if (dx == fw - 1'b1) begin
            dx <= '0;
            dy <= dy + 1'b1;
            rd_slot <= (rd_slot == SLOT_BITS'(MAX_FILTER - 1)) ? '0 : rd_slot + 1'b1;
          end else begin
            dx <= dx + 1'b1;
          end
        end
        ST_DR2: state <= ST_DR3;
        ST_DR3: state <= ST_OUT;
        ST_OUT: if (!out_full || res.ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Channel lanes share the tap and the window walk.
  lane_ctrl_t lctrl;
  assign lctrl.clear  = (state == ST_DR1);
  assign lctrl.acc_en = acc_valid;

  logic signed [OUT_BITS-1:0] acc0, acc1, acc2;
  logic signed [SAMPLE_BITS-1:0] s0, s1, s2;
  assign s0 = line_q[SAMPLE_BITS-1:0];
  assign s1 = line_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign s2 = line_q[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  swf_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane0 (.clk, .ctrl(lctrl), .sample(s0),
    .tap(tap_q), .acc(acc0));
  swf_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane1 (.clk, .ctrl(lctrl), .sample(s1),
    .tap(tap_q), .acc(acc1));
  swf_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane2 (.clk, .ctrl(lctrl), .sample(s2),
    .tap(tap_q), .acc(acc2));

  // Output register merges the lane sums with the position.
  wire load_out = (state == ST_OUT) && (!out_full || res.ready);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (load_out) begin
      out_full <= 1'b1;
    end else if (res.ready) begin
      out_full <= 1'b0;
    end
    if (load_out) begin
      res.out_ch0 <= acc0;
      res.out_ch1 <= acc1;
      res.out_ch2 <= acc2;
      res.out_row <= POS_BITS'(orow);
      res.out_col <= POS_BITS'(ocol);
      res.last    <= is_last;
    end
  end
  assign res.valid = out_full;

endmodule
